@@ hw/rtl/pcqp_pkg.sv @@
// shared codes, defaults and sideband type of the penalty curve evaluator
package pcqp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [1:0] {
    ACT_VALUE   = 2'd0,
    ACT_SLOPE   = 2'd1,
    ACT_BEND    = 2'd2,
    ACT_INVERSE = 2'd3
  } action_t;

  // how the quotient is turned into a magnitude at the end of the chain
  typedef enum logic [1:0] {
    KIND_MAG  = 2'd0,
    KIND_CUBE = 2'd1,
    KIND_SQRT = 2'd2
  } kind_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVATURE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KNEE_WIDTH = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_X    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT_Y    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP_X     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP_Y     = 3'd5;

  typedef struct packed {
    action_t act;
    kind_t   kind;
    logic    fault;
    logic    ovf;
  } side_t;

endpackage

@@ hw/rtl/pcqp_div_cell.sv @@
// one restoring division cell: settles one quotient bit per cycle while adv is high
module pcqp_div_cell #(
  parameter int ND  = 132,
  parameter int DW  = 66,
  parameter int QB  = 96,
  parameter int IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [ND-1:0]          in_rem,
  input  logic [DW-1:0]          in_d,
  input  logic [QB-1:0]          in_q,
  input  pcqp_pkg::side_t        in_side,
  output logic                   out_valid,
  output logic [ND-1:0]          out_rem,
  output logic [DW-1:0]          out_d,
  output logic [QB-1:0]          out_q,
  output pcqp_pkg::side_t        out_side
);

  localparam int CW = (DW + IDX > ND) ? DW + IDX : ND;

  logic [CW-1:0] dsh;
  logic [CW-1:0] rem_x;
  logic          ge;

  assign dsh   = CW'(in_d) << IDX;
  assign rem_x = CW'(in_rem);
  assign ge    = rem_x >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem  <= ge ? ND'(rem_x - dsh) : in_rem;
      out_q    <= in_q | (ge ? (QB'(1) << IDX) : QB'(0));
      out_d    <= in_d;
      out_side <= in_side;
    end
  end

endmodule

@@ hw/rtl/pcqp_root_cell.sv @@
// one digit cell of the square / cube root: tries bit B of the root
module pcqp_root_cell #(
  parameter int QB = 96,
  parameter int RB = 34,
  parameter int B  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [QB-1:0]       in_q,
  input  logic [RB-1:0]       in_r,
  input  logic [2*RB-1:0]     in_r2,
  input  logic [3*RB-1:0]     in_r3,
  input  pcqp_pkg::side_t     in_side,
  output logic                out_valid,
  output logic [QB-1:0]       out_q,
  output logic [RB-1:0]       out_r,
  output logic [2*RB-1:0]     out_r2,
  output logic [3*RB-1:0]     out_r3,
  output pcqp_pkg::side_t     out_side
);

  localparam int R2W = 2 * RB;
  localparam int R3W = 3 * RB;
  localparam int MW  = (R3W > QB) ? R3W : QB;

  logic [R2W-1:0] c2;
  logic [R3W-1:0] c3;
  logic [R3W-1:0] t_r2;
  logic [R3W-1:0] t_r;
  logic           cube;
  logic           fit;

  // (r + 2^B)^2 and (r + 2^B)^3 from running r, r^2, r^3 with shifts and adds
  assign t_r2 = R3W'(in_r2) << B;
  assign t_r  = R3W'(in_r) << (2 * B);
  assign c2   = in_r2 + (R2W'(in_r) << (B + 1)) + (R2W'(1) << (2 * B));
  assign c3   = in_r3 + t_r2 + (t_r2 << 1) + t_r + (t_r << 1) + (R3W'(1) << (3 * B));
  assign cube = in_side.kind == pcqp_pkg::KIND_CUBE;
  assign fit  = cube ? (MW'(c3) <= MW'(in_q)) : (MW'(c2) <= MW'(in_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q    <= in_q;
      out_side <= in_side;
      if (fit) begin
        out_r  <= in_r | (RB'(1) << B);
        out_r2 <= c2;
        out_r3 <= c3;
      end else begin
        out_r  <= in_r;
        out_r2 <= in_r2;
        out_r3 <= in_r3;
      end
    end
  end

endmodule

@@ hw/rtl/pcqp_front.sv @@
// front stages: coordinate mapping, product chain and dividend / divisor setup
module pcqp_front #(
  parameter int FB = pcqp_pkg::FRAC_BITS_DEF,
  parameter int WB = pcqp_pkg::WORD_BITS_DEF,
  parameter int ND = 4 * WB + 4,
  parameter int DW = WB + 2 + 2 * FB,
  parameter int QB = 3 * WB
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  pcqp_pkg::action_t      in_act,
  input  logic signed [WB-1:0]   operand,
  input  logic [WB-2:0]          curv,
  input  logic [WB-2:0]          knee,
  input  logic signed [WB-1:0]   shift_x,
  input  logic signed [WB-1:0]   shift_y,
  input  logic                   flip_x,
  input  logic                   flip_y,
  output logic                   out_valid,
  output logic [ND-1:0]          out_n,
  output logic [DW-1:0]          out_d,
  output pcqp_pkg::side_t        out_side
);

  localparam int XW  = WB + 2;
  localparam int PW  = 2 * XW;
  localparam int P2W = PW + WB + 1;
  localparam int YW  = WB + 2;
  localparam int TOL = (1 << FB) / 100000;
  localparam int PLW = XW + WB;
  localparam int MPW = XW + WB - 1;

  // stage a: mapped coordinate
  logic                  a_valid;
  pcqp_pkg::action_t     a_act;
  logic signed [WB:0]    a_uy;
  logic signed [WB:0]    op_x, tx_x, ty_x, uy_next;

  assign op_x = {operand[WB-1], operand};
  assign tx_x = {shift_x[WB-1], shift_x};
  assign ty_x = {shift_y[WB-1], shift_y};

  always_comb begin
    if (in_act == pcqp_pkg::ACT_INVERSE) begin
      uy_next = flip_y ? ty_x - op_x : op_x - ty_x;
    end else begin
      uy_next = flip_x ? tx_x - op_x : op_x - tx_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_act <= in_act;
      a_uy  <= uy_next;
    end
  end

  // stage b: region and factor selection
  logic                  pos, cub;
  logic [WB-1:0]         uu;
  logic [XW-1:0]         three_u, e_x;
  logic [YW-1:0]         neg_y;
  logic [XW-1:0]         x1_n, y1_n, xr_n, yr_n;
  logic [WB-1:0]         x2_n;
  logic                  addr_n, inv_n;
  logic [DW-1:0]         d_n;
  pcqp_pkg::side_t       side_n;

  logic                  b_valid;
  logic [XW-1:0]         b_x1, b_y1, b_xr, b_yr, b_y3;
  logic [WB-1:0]         b_x2;
  logic                  b_addr, b_inv;
  logic [DW-1:0]         b_d;
  pcqp_pkg::side_t       b_side;

  assign pos     = !a_uy[WB] && (a_uy != '0);
  assign uu      = a_uy[WB-1:0];
  assign cub     = uu <= WB'(knee);
  assign e_x     = XW'(knee);
  assign three_u = XW'(uu) + (XW'(uu) << 1);
  assign neg_y   = YW'(0) - YW'(a_uy);

  always_comb begin
    x1_n        = '0;
    y1_n        = '0;
    x2_n        = WB'(1);
    xr_n        = '0;
    yr_n        = '0;
    addr_n      = 1'b0;
    inv_n       = 1'b0;
    d_n         = DW'(1);
    side_n.act  = a_act;
    side_n.kind = pcqp_pkg::KIND_MAG;
    side_n.fault = 1'b0;
    side_n.ovf  = 1'b0;
    case (a_act)
      pcqp_pkg::ACT_VALUE: begin
        if (pos && cub) begin
          x1_n = XW'(uu);
          y1_n = XW'(uu);
          x2_n = uu;
          d_n  = (DW'(knee) << (2 * FB)) + (DW'(knee) << (2 * FB + 1));
        end else if (pos) begin
          // c*(3u(u-e) + e^2) over 3
          x1_n   = XW'(uu) - e_x;
          y1_n   = three_u;
          xr_n   = e_x;
          yr_n   = e_x;
          addr_n = 1'b1;
          d_n    = DW'(3) << (2 * FB);
        end
      end
      pcqp_pkg::ACT_SLOPE: begin
        if (pos && cub) begin
          x1_n = XW'(uu);
          y1_n = XW'(uu);
          d_n  = DW'(knee) << FB;
        end else if (pos) begin
          x1_n = (XW'(uu) << 1) - e_x;
          y1_n = XW'(1);
          d_n  = DW'(1) << FB;
        end
      end
      pcqp_pkg::ACT_BEND: begin
        if (pos && cub) begin
          x1_n = XW'(uu);
          y1_n = XW'(2);
          d_n  = DW'(knee);
        end else if (pos) begin
          x1_n = XW'(2);
          y1_n = XW'(1);
        end
      end
      pcqp_pkg::ACT_INVERSE: begin
        // product lane gives c*e^2, side lane gives 3y*e; a level at or
        // below the flat region leaves a zero magnitude
        if (pos) begin
          x1_n = e_x;
          y1_n = e_x;
          xr_n = three_u;
          yr_n = e_x;
        end
        inv_n = pos;
        side_n.fault = !pos && (neg_y > YW'(TOL));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_x1   <= x1_n;
      b_y1   <= y1_n;
      b_x2   <= x2_n;
      b_xr   <= xr_n;
      b_yr   <= yr_n;
      b_y3   <= three_u;
      b_addr <= addr_n;
      b_inv  <= inv_n;
      b_d    <= d_n;
      b_side <= side_n;
    end
  end

  // stage c: first products
  logic                  c_valid;
  logic [PW-1:0]         c_p, c_r;
  logic [XW-1:0]         c_y3;
  logic [WB-1:0]         c_x2;
  logic                  c_addr, c_inv;
  logic [DW-1:0]         c_d;
  pcqp_pkg::side_t       c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_p    <= PW'(b_x1) * PW'(b_y1);
      c_r    <= PW'(b_xr) * PW'(b_yr);
      c_y3   <= b_y3;
      c_x2   <= b_x2;
      c_addr <= b_addr;
      c_inv  <= b_inv;
      c_d    <= b_d;
      c_side <= b_side;
    end
  end

  // stage d: partial products of the third factor
  logic                  d_valid;
  logic [PLW-1:0]        d_pl, d_ph;
  logic [PW-1:0]         d_r;
  logic [XW-1:0]         d_y3;
  logic                  d_addr, d_inv;
  logic [DW-1:0]         d_d;
  pcqp_pkg::side_t       d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_pl   <= PLW'(c_p[XW-1:0]) * PLW'(c_x2);
      d_ph   <= PLW'(c_p[PW-1:XW]) * PLW'(c_x2);
      d_r    <= c_r;
      d_y3   <= c_y3;
      d_addr <= c_addr;
      d_inv  <= c_inv;
      d_d    <= c_d;
      d_side <= c_side;
    end
  end

  // stage p: partial sum plus the e^2 term
  logic                  p_valid;
  logic [P2W-1:0]        p_p2;
  logic [PW-1:0]         p_r;
  logic [XW-1:0]         p_y3;
  logic                  p_inv;
  logic [DW-1:0]         p_d;
  pcqp_pkg::side_t       p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_p2   <= P2W'(d_pl) + (P2W'(d_ph) << XW) + (d_addr ? P2W'(d_r) : P2W'(0));
      p_r    <= d_r;
      p_y3   <= d_y3;
      p_inv  <= d_inv;
      p_d    <= d_d;
      p_side <= d_side;
    end
  end

  // stage m: partial products with curvature
  logic                  m_valid;
  logic [3*XW-1:0]       p2_x;
  logic [MPW-1:0]        m_n0, m_n1, m_n2;
  logic [PW-1:0]         m_r;
  logic [XW-1:0]         m_y3;
  logic                  m_inv;
  logic [DW-1:0]         m_d;
  pcqp_pkg::side_t       m_side;

  assign p2_x = (3 * XW)'(p_p2);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_n0   <= MPW'(p2_x[XW-1:0]) * MPW'(curv);
      m_n1   <= MPW'(p2_x[2*XW-1:XW]) * MPW'(curv);
      m_n2   <= MPW'(p2_x[3*XW-1:2*XW]) * MPW'(curv);
      m_r    <= p_r;
      m_y3   <= p_y3;
      m_inv  <= p_inv;
      m_d    <= p_d;
      m_side <= p_side;
    end
  end

  // stage e: times curvature, partial products summed
  logic                  e_valid;
  logic [ND-1:0]         e_n;
  logic [PW-1:0]         e_r;
  logic [XW-1:0]         e_y3;
  logic                  e_inv;
  logic [DW-1:0]         e_d;
  pcqp_pkg::side_t       e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_n    <= ND'(m_n0) + (ND'(m_n1) << XW) + (ND'(m_n2) << (2 * XW));
      e_r    <= m_r;
      e_y3   <= m_y3;
      e_inv  <= m_inv;
      e_d    <= m_d;
      e_side <= m_side;
    end
  end

  // stage f: inverse picks cubic or quadratic region
  logic                  f_valid;
  logic [ND-1:0]         f_n, n_sel, t3;
  logic [DW-1:0]         f_d, d_sel;
  pcqp_pkg::side_t       f_side, side_sel;
  logic                  cubic;

  assign t3    = ND'(e_y3) << (2 * FB);
  assign cubic = t3 <= e_n;

  always_comb begin
    n_sel    = e_n;
    d_sel    = e_d;
    side_sel = e_side;
    if (e_inv) begin
      if (cubic) begin
        n_sel         = ND'(e_r) << (2 * FB);
        d_sel         = DW'(curv);
        side_sel.kind = pcqp_pkg::KIND_CUBE;
      end else begin
        n_sel         = (ND'(e_y3) << (2 * FB + 2)) - e_n;
        d_sel         = DW'(curv) + (DW'(curv) << 1);
        side_sel.kind = pcqp_pkg::KIND_SQRT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_n    <= n_sel;
      f_d    <= d_sel;
      f_side <= side_sel;
    end
  end

  // stage g: quotient range check
  pcqp_pkg::side_t side_g;

  always_comb begin
    side_g     = f_side;
    side_g.ovf = (f_n >> QB) >= ND'(f_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_n    <= f_n;
      out_d    <= f_d;
      out_side <= side_g;
    end
  end

endmodule

@@ hw/rtl/piecewise_cubic_quadratic_penalty.sv @@
// top level of the piecewise cubic / quadratic penalty curve evaluator
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: operand, tuser: action
//  m_*      out  m_tvalid/m_tready  tdata: result, tuser: invert_fault, saturated
//  cfg_*    in   cfg_write          cfg_index, cfg_data
//
// one item per cycle while the chain advances; each item passes through the front stages,
// the divider cells (one quotient bit each), the root cells and the output register.
// reset clears all valid bits and loads the register defaults.
// the chain holds only while the output register is full, not taken, and the last
// cell holds an item; otherwise it moves and takes a transfer every cycle.
module piecewise_cubic_quadratic_penalty #(
  parameter int FRAC_BITS = pcqp_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = pcqp_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0]       s_tdata,   // operand
  input  logic [1:0]                           s_tuser,   // action
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]       m_tdata,   // result
  output logic [1:0]                           m_tuser,   // invert_fault, saturated
  input  logic                                 cfg_write,
  input  logic [pcqp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [WORD_BITS-1:0]                 cfg_data
);

  localparam int WB  = WORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int DB  = ((WORD_BITS + 7) / 8) * 8;
  localparam int QB  = 3 * WB;
  localparam int RB  = WB + 2;
  localparam int DW  = WB + 2 + 2 * FB;
  localparam int ND  = (4 * WB + 4 > 2 * WB + 6 + 2 * FB) ? 4 * WB + 4 : 2 * WB + 6 + 2 * FB;
  localparam int XMW = WB + 2;
  localparam int VW  = WB + 4;
  localparam logic signed [VW-1:0] VMAX = {{5{1'b0}}, {(WB-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {{5{1'b1}}, {(WB-1){1'b0}}};
  localparam logic [XMW-1:0]       CAP  = XMW'(1) << (WB + 1);

  // configuration registers
  logic [WB-2:0]        curvature, knee_width;
  logic signed [WB-1:0] shift_x, shift_y;
  logic                 flip_x, flip_y;
  logic [WB-2:0]        curv_c, knee_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      curvature  <= (WB-1)'(1) << FB;
      knee_width <= (WB-1)'(1) << FB;
      shift_x    <= '0;
      shift_y    <= '0;
      flip_x     <= 1'b0;
      flip_y     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        pcqp_pkg::REG_CURVATURE:  curvature  <= cfg_data[WB-2:0];
        pcqp_pkg::REG_KNEE_WIDTH: knee_width <= cfg_data[WB-2:0];
        pcqp_pkg::REG_SHIFT_X:    shift_x    <= cfg_data;
        pcqp_pkg::REG_SHIFT_Y:    shift_y    <= cfg_data;
        pcqp_pkg::REG_FLIP_X:     flip_x     <= cfg_data[0];
        pcqp_pkg::REG_FLIP_Y:     flip_y     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // zero coefficients act as one lsb
  assign curv_c = (curvature == '0) ? (WB-1)'(1) : curvature;
  assign knee_c = (knee_width == '0) ? (WB-1)'(1) : knee_width;

  logic adv;
  logic out_valid;

  assign s_tready = adv;

  // division chain
  logic            dv_valid [QB+1];
  logic [ND-1:0]   dv_rem   [QB+1];
  logic [DW-1:0]   dv_d     [QB+1];
  logic [QB-1:0]   dv_q     [QB+1];
  pcqp_pkg::side_t dv_side  [QB+1];

  pcqp_front #(.FB(FB), .WB(WB), .ND(ND), .DW(DW), .QB(QB)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .in_act    (pcqp_pkg::action_t'(s_tuser)),
    .operand   (s_tdata[WB-1:0]),
    .curv      (curv_c),
    .knee      (knee_c),
    .shift_x   (shift_x),
    .shift_y   (shift_y),
    .flip_x    (flip_x),
    .flip_y    (flip_y),
    .out_valid (dv_valid[0]),
    .out_n     (dv_rem[0]),
    .out_d     (dv_d[0]),
    .out_side  (dv_side[0])
  );

  assign dv_q[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_div
    pcqp_div_cell #(.ND(ND), .DW(DW), .QB(QB), .IDX(QB - 1 - k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (dv_valid[k]),
      .in_rem    (dv_rem[k]),
      .in_d      (dv_d[k]),
      .in_q      (dv_q[k]),
      .in_side   (dv_side[k]),
      .out_valid (dv_valid[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_d     (dv_d[k+1]),
      .out_q     (dv_q[k+1]),
      .out_side  (dv_side[k+1])
    );
  end

  // root chain
  logic            rt_valid [RB+1];
  logic [QB-1:0]   rt_q     [RB+1];
  logic [RB-1:0]   rt_r     [RB+1];
  logic [2*RB-1:0] rt_r2    [RB+1];
  logic [3*RB-1:0] rt_r3    [RB+1];
  pcqp_pkg::side_t rt_side  [RB+1];

  assign rt_valid[0] = dv_valid[QB];
  assign rt_q[0]     = dv_q[QB];
  assign rt_r[0]     = '0;
  assign rt_r2[0]    = '0;
  assign rt_r3[0]    = '0;
  assign rt_side[0]  = dv_side[QB];

  for (genvar k = 0; k < RB; k++) begin : g_root
    pcqp_root_cell #(.QB(QB), .RB(RB), .B(RB - 1 - k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (rt_valid[k]),
      .in_q      (rt_q[k]),
      .in_r      (rt_r[k]),
      .in_r2     (rt_r2[k]),
      .in_r3     (rt_r3[k]),
      .in_side   (rt_side[k]),
      .out_valid (rt_valid[k+1]),
      .out_q     (rt_q[k+1]),
      .out_r     (rt_r[k+1]),
      .out_r2    (rt_r2[k+1]),
      .out_r3    (rt_r3[k+1]),
      .out_side  (rt_side[k+1])
    );
  end

  // finish: magnitude, sign, shift and clamp
  logic                 last_valid;
  logic [QB-1:0]        lq;
  logic [RB-1:0]        lr;
  pcqp_pkg::side_t      ls;
  logic signed [WB-1:0] base;
  logic                 neg;
  logic [XMW-1:0]       xmag;
  logic [WB+2:0]        half_sum;
  logic signed [VW-1:0] base_v, x_v, v;
  logic                 sat;
  logic [WB-1:0]        res;

  assign last_valid = rt_valid[RB];
  assign lq         = rt_q[RB];
  assign lr         = rt_r[RB];
  assign ls         = rt_side[RB];
  assign half_sum   = (WB+3)'(knee_c) + (WB+3)'(lr);

  always_comb begin
    case (ls.act)
      pcqp_pkg::ACT_VALUE: begin
        base = shift_y;
        neg  = flip_y;
      end
      pcqp_pkg::ACT_SLOPE: begin
        base = '0;
        neg  = flip_x ^ flip_y;
      end
      pcqp_pkg::ACT_BEND: begin
        base = '0;
        neg  = flip_y;
      end
      pcqp_pkg::ACT_INVERSE: begin
        base = shift_x;
        neg  = flip_x;
      end
      default: begin
        base = '0;
        neg  = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ls.kind)
      pcqp_pkg::KIND_MAG: begin
        xmag = (ls.ovf || ((lq >> (WB + 1)) != '0)) ? CAP : lq[XMW-1:0];
      end
      pcqp_pkg::KIND_CUBE: begin
        xmag = lr;
      end
      pcqp_pkg::KIND_SQRT: begin
        // root beyond its digit range saturates anyway
        xmag = (ls.ovf || ((lq >> (2 * WB + 4)) != '0)) ? CAP : half_sum[XMW:1];
      end
      default: begin
        xmag = '0;
      end
    endcase
  end

  assign base_v = VW'(base);
  assign x_v    = VW'(xmag);
  assign v      = neg ? base_v - x_v : base_v + x_v;

  always_comb begin
    sat = 1'b0;
    res = v[WB-1:0];
    if (v > VMAX) begin
      sat = 1'b1;
      res = VMAX[WB-1:0];
    end else if (v < VMIN) begin
      sat = 1'b1;
      res = VMIN[WB-1:0];
    end
  end

  // output register
  logic [WB-1:0] out_res;
  logic          out_fault;
  logic          out_sat;

  assign adv = m_tready || !out_valid || !last_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_res   <= res;
      out_fault <= ls.fault;
      out_sat   <= sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = DB'(out_res);
  assign m_tuser  = {out_sat, out_fault};

  // input is refused only while a finished result waits behind a full last cell
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input refused without an output stall");

  // a fault answer is the flat boundary and never clamps
  a_fault_nosat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
    else $error("fault and saturation flagged together");

endmodule

@@ tb/piecewise_cubic_quadratic_penalty_test.sv @@
// self-checking testbench for the piecewise cubic / quadratic penalty evaluator
module piecewise_cubic_quadratic_penalty_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef bit [255:0] wide_t;

  typedef struct {
    bit [31:0] result;
    bit        fault;
    bit        sat;
  } curve_out_t;

  localparam longint MAG_LIMIT = 64'd1 << 52;

  class penalty_scoreboard;
    bit [30:0]  curvature = 31'h10000;
    bit [30:0]  knee = 31'h10000;
    bit [31:0]  shift_x = 0;
    bit [31:0]  shift_y = 0;
    bit         flip_x = 0;
    bit         flip_y = 0;
    curve_out_t pending[$];
    int         errors = 0;

    function void set_reg(bit [2:0] idx, bit [31:0] val);
      case (idx)
        pcqp_pkg::REG_CURVATURE:  curvature = val[30:0];
        pcqp_pkg::REG_KNEE_WIDTH: knee = val[30:0];
        pcqp_pkg::REG_SHIFT_X:    shift_x = val;
        pcqp_pkg::REG_SHIFT_Y:    shift_y = val;
        pcqp_pkg::REG_FLIP_X:     flip_x = val[0];
        pcqp_pkg::REG_FLIP_Y:     flip_y = val[0];
        default: ;
      endcase
    endfunction

    function longint clamp_mag(wide_t a);
      if (a[255:64] != 0 || a[63:0] > MAG_LIMIT) return MAG_LIMIT;
      return longint'(a[63:0]);
    endfunction

    function longint floor_root(wide_t q, bit cube);
      bit [63:0] r;
      bit [63:0] c;
      wide_t p;
      r = 0;
      for (int b = 54; b >= 0; b--) begin
        c = r | (64'd1 << b);
        p = wide_t'(c) * wide_t'(c);
        if (cube) p = p * wide_t'(c);
        if (p <= q) r = c;
      end
      return longint'(r);
    endfunction

    function curve_out_t apply_offset(longint base, bit neg, longint mag);
      curve_out_t o;
      longint v;
      if (mag > MAG_LIMIT) mag = MAG_LIMIT;
      v = neg ? base - mag : base + mag;
      o.sat = 0;
      o.fault = 0;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        o.sat = 1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        o.sat = 1;
      end
      o.result = v[31:0];
      return o;
    endfunction

    function curve_out_t evaluate(pcqp_pkg::action_t act, bit [31:0] operand);
      curve_out_t o;
      longint op, tx, ty, u, y, mag;
      wide_t c, e, uu, yy, n, ce2;
      bit cubic;
      op = longint'(signed'(operand));
      tx = longint'(signed'(shift_x));
      ty = longint'(signed'(shift_y));
      c = (curvature == 0) ? 1 : wide_t'(curvature);
      e = (knee == 0) ? 1 : wide_t'(knee);
      if (act != pcqp_pkg::ACT_INVERSE) begin
        u = flip_x ? tx - op : op - tx;
        uu = wide_t'(u);
        cubic = u > 0 && uu <= e;
        mag = 0;
        if (u > 0) begin
          case (act)
            pcqp_pkg::ACT_VALUE:
              if (cubic) mag = clamp_mag((c * uu * uu * uu) / ((3 * e) << 32));
              else mag = clamp_mag((c * (3 * uu * uu + e * e - 3 * e * uu)) /
                                   (wide_t'(3) << 32));
            pcqp_pkg::ACT_SLOPE:
              if (cubic) mag = clamp_mag((c * uu * uu) / (e << 16));
              else mag = clamp_mag((c * (2 * uu - e)) >> 16);
            default:
              if (cubic) mag = clamp_mag((2 * c * uu) / e);
              else mag = clamp_mag(2 * c);
          endcase
        end
        if (act == pcqp_pkg::ACT_VALUE) o = apply_offset(ty, flip_y, mag);
        else if (act == pcqp_pkg::ACT_SLOPE) o = apply_offset(0, flip_x ^ flip_y, mag);
        else o = apply_offset(0, flip_y, mag);
      end else begin
        y = flip_y ? ty - op : op - ty;
        if (y <= 0) begin
          // tolerance rounds to zero lsb at 16 fraction bits
          o.fault = (-y) > ((64'd1 << 16) / 100000);
          o.result = shift_x;
          o.sat = 0;
        end else begin
          yy = wide_t'(y);
          ce2 = c * e * e;
          if (((3 * yy) << 32) <= ce2)
            mag = floor_root((((3 * yy) * e) << 32) / c, 1);
          else
            mag = (longint'(e) + floor_root((((12 * yy) << 32) - ce2) / (3 * c), 0)) >>> 1;
          o = apply_offset(tx, flip_x, mag);
        end
      end
      return o;
    endfunction

    function void note_item(pcqp_pkg::action_t act, bit [31:0] operand);
      pending.insert(pending.size(), evaluate(act, operand));
    endfunction

    function void check_result(bit [31:0] result, bit fault, bit sat);
      curve_out_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h fault %b sat %b", $time, result, fault, sat);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x.result !== result) begin
        $display("%0t: result expected %h actual %h", $time, x.result, result);
        errors++;
      end
      if (x.fault !== fault) begin
        $display("%0t: invert_fault expected %b actual %b", $time, x.fault, fault);
        errors++;
      end
      if (x.sat !== sat) begin
        $display("%0t: saturated expected %b actual %b", $time, x.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;   // operand
  logic [1:0]  s_tuser = 0;   // action
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;       // result
  logic [1:0]  m_tuser;       // invert_fault, saturated
  logic        cfg_write = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;

  penalty_scoreboard sb = new();
  bit steady = 0;
  bit hold_req = 0;

  piecewise_cubic_quadratic_penalty DUT (.*);

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("[piecewise_cubic_quadratic_penalty] ERROR");
    $finish;
  end

  // result side: checks transfers and throttles m_tready
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0], m_tuser[1]);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 500;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 0;
      end else begin
        m_tready <= steady || $urandom_range(0, 99) >= 17;
      end
    end
  end

  task automatic send_item(pcqp_pkg::action_t act, bit [31:0] operand);
    s_tvalid <= 1;
    s_tdata <= operand;
    s_tuser <= act;
    do @(posedge clk); while (!s_tready);
    sb.note_item(act, operand);
    if (!steady && $urandom_range(0, 99) < 17) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_write high; the caller drops it after the last write
  task automatic write_reg(bit [2:0] idx, bit [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(bit [30:0] c, bit [30:0] e, bit [31:0] sx, bit [31:0] sy,
                             bit fx, bit fy);
    write_reg(pcqp_pkg::REG_CURVATURE, {1'b0, c});
    write_reg(pcqp_pkg::REG_KNEE_WIDTH, {1'b0, e});
    write_reg(pcqp_pkg::REG_SHIFT_X, sx);
    write_reg(pcqp_pkg::REG_SHIFT_Y, sy);
    write_reg(pcqp_pkg::REG_FLIP_X, {31'b0, fx});
    write_reg(pcqp_pkg::REG_FLIP_Y, {31'b0, fy});
    cfg_write <= 0;
  endtask

  // operands cluster near the flat boundary and the knee, with some full-range noise
  function automatic bit [31:0] pick_operand(pcqp_pkg::action_t act);
    longint center, span;
    center = (act == pcqp_pkg::ACT_INVERSE) ? longint'(signed'(sb.shift_y))
                                            : longint'(signed'(sb.shift_x));
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return 32'(center + longint'(signed'($urandom >> $urandom_range(0, 31))));
      default: begin
        span = 2 * longint'(sb.knee) + 2;
        return 32'(center + ($urandom_range(0, 1) ? 1 : -1) *
                   longint'($urandom_range(0, 32'(span > 64'hffffffff ? 64'hffffffff : span))));
      end
    endcase
  endfunction

  task automatic random_items(int count);
    pcqp_pkg::action_t act;
    for (int i = 0; i < count; i++) begin
      act = pcqp_pkg::action_t'($urandom_range(0, 3));
      send_item(act, pick_operand(act));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: boundary, knee, extremes and the inverse split near c*eps^2/3
    for (int a = 0; a < 3; a++) begin
      send_item(pcqp_pkg::action_t'(a), 32'h0);
      send_item(pcqp_pkg::action_t'(a), 32'h10000);
      send_item(pcqp_pkg::action_t'(a), 32'h10001);
      send_item(pcqp_pkg::action_t'(a), 32'h7fffffff);
      send_item(pcqp_pkg::action_t'(a), 32'h80000000);
    end
    send_item(pcqp_pkg::ACT_INVERSE, 32'h5555);
    send_item(pcqp_pkg::ACT_INVERSE, 32'h5556);
    send_item(pcqp_pkg::ACT_INVERSE, 32'h0);
    send_item(pcqp_pkg::ACT_INVERSE, 32'hffffffff);
    send_item(pcqp_pkg::ACT_INVERSE, 32'h80000000);
    send_item(pcqp_pkg::ACT_INVERSE, 32'h7fffffff);
    random_items(300);
    drain();

    steady = 1;
    load_config(31'd1, 31'd1, 32'h80000000, 32'h7fffffff, 1, 0);
    random_items(300);
    drain();
    steady = 0;

    load_config(31'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 1);
    steady = 1;
    hold_req = 1;
    random_items(300);
    steady = 0;
    drain();

    load_config(31'($urandom), 31'($urandom), $urandom, $urandom, 1, 1);
    random_items(150);
    drain();
    random_items(150);
    drain();

    load_config(31'h30000, 31'h8000, $urandom >> 12, $urandom >> 12, 0, 0);
    random_items(300);
    drain();

    load_config(31'($urandom >> $urandom_range(0, 30)), 31'($urandom >> $urandom_range(0, 30)),
                $urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    random_items(300);
    drain();

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[piecewise_cubic_quadratic_penalty] OK");
    else
      $display("[piecewise_cubic_quadratic_penalty] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pcqp_pkg.sv
hw/rtl/pcqp_div_cell.sv
hw/rtl/pcqp_root_cell.sv
hw/rtl/pcqp_front.sv
hw/rtl/piecewise_cubic_quadratic_penalty.sv
tb/piecewise_cubic_quadratic_penalty_test.sv
